// ===== hw/rtl/ble_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_pkg
// Shared command codes and controller/datapath bundles for the list engine.
// ----------------------------------------------------------------------------
package ble_pkg;

    // list operation codes
    typedef enum logic [2:0] {
        F_APPEND  = 3'd0,
        F_POP     = 3'd1,
        F_INSERT  = 3'd2,
        F_REMOVE  = 3'd3,
        F_REVERSE = 3'd4,
        F_SORT    = 3'd5,
        F_COUNT   = 3'd6,
        F_FIND    = 3'd7
    } t_func;

    // memory address sources
    typedef enum logic [3:0] {
        A_I, A_IM1, A_IP1, A_J, A_JM1, A_JP1, A_LEN, A_LENM1, A_POS
    } t_asel;

    // write data sources
    typedef enum logic [1:0] {
        D_VAL, D_RDATA, D_A
    } t_dsel;

    // index register updates
    typedef enum logic [2:0] {
        X_HOLD, X_ZERO, X_LEN, X_INC, X_DEC
    } t_xop;

    // length register updates
    typedef enum logic [1:0] {
        L_HOLD, L_INC, L_DEC
    } t_lop;

    // result register updates
    typedef enum logic [2:0] {
        R_HOLD, R_FAIL, R_RDATA, R_INC, R_IDX
    } t_rop;

    localparam logic [31:0] FAIL_WORD = 32'hFFFF_FFFF;

    // controller to datapath
    typedef struct packed {
        logic  load;
        logic  rd_en;
        t_asel rd_sel;
        logic  wr_en;
        t_asel wr_sel;
        t_dsel wd_sel;
        logic  ld_a;
        t_xop  i_op;
        t_xop  j_op;
        t_lop  len_op;
        t_rop  res_op;
        logic  out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_func func;
        logic  full;
        logic  empty;
        logic  pos_bad;
        logic  i_gt_pos;
        logic  i_lt_len;
        logic  ip1_lt_len;
        logic  ip1_lt_j;
        logic  inner_more;
        logic  eq;
        logic  gt;
        logic  out_busy;
    } t_sts;

endpackage

// ===== hw/rtl/ble_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_datapath
// List memory, index registers, compare logic and output word register.
// ----------------------------------------------------------------------------
module ble_datapath import ble_pkg::*; #(
    parameter int CAPACITY = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [2:0]         i_func,
    input  logic signed [31:0] i_value,
    input  logic [7:0]         i_position,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_result,
    output logic               o_ok,
    output logic [7:0]         o_length
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);

    logic [31:0]   r_mem [CAPACITY];
    logic [31:0]   r_rdata;
    logic [31:0]   r_a;
    logic [31:0]   r_val;
    logic [7:0]    r_pos;
    t_func         r_func;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_i, n_i;
    logic [LW-1:0] r_j, n_j;
    logic [31:0]   r_res, n_res;
    logic          r_ok, n_ok;
    logic          r_out_valid;
    logic [31:0]   r_out_res;
    logic          r_out_ok;
    logic [7:0]    r_out_len;
    logic [LW-1:0] w_raddr, w_waddr;
    logic [31:0]   w_wdata;

    // address selection
    function automatic logic [LW-1:0] f_addr(t_asel s, logic [LW-1:0] i, logic [LW-1:0] j,
                                             logic [LW-1:0] len, logic [7:0] pos);
        logic [LW-1:0] a;
        a = '0;
        case (s)
            A_I:     a = i;
            A_IM1:   a = i - LW'(1);
            A_IP1:   a = i + LW'(1);
            A_J:     a = j;
            A_JM1:   a = j - LW'(1);
            A_JP1:   a = j + LW'(1);
            A_LEN:   a = len;
            A_LENM1: a = len - LW'(1);
            A_POS:   a = LW'(pos);
            default: a = '0;
        endcase
        return a;
    endfunction

    assign w_raddr = f_addr(i_cmd.rd_sel, r_i, r_j, r_len, r_pos);
    assign w_waddr = f_addr(i_cmd.wr_sel, r_i, r_j, r_len, r_pos);

    always_comb begin
        case (i_cmd.wd_sel)
            D_VAL:   w_wdata = r_val;
            D_RDATA: w_wdata = r_rdata;
            D_A:     w_wdata = r_a;
            default: w_wdata = r_val;
        endcase
    end

    // list memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[w_waddr[AW-1:0]] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_raddr[AW-1:0]];
        end
        if (i_cmd.ld_a) begin
            r_a <= r_rdata;
        end
    end

    // input word capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val  <= i_value;
            r_pos  <= i_position;
            r_func <= t_func'(i_func);
        end
    end

    // index, length and result updates
    always_comb begin
        n_i = r_i;
        case (i_cmd.i_op)
            X_ZERO:  n_i = '0;
            X_LEN:   n_i = r_len;
            X_INC:   n_i = r_i + LW'(1);
            X_DEC:   n_i = r_i - LW'(1);
            default: n_i = r_i;
        endcase
        n_j = r_j;
        case (i_cmd.j_op)
            X_ZERO:  n_j = '0;
            X_LEN:   n_j = r_len;
            X_INC:   n_j = r_j + LW'(1);
            X_DEC:   n_j = r_j - LW'(1);
            default: n_j = r_j;
        endcase
        n_len = r_len;
        case (i_cmd.len_op)
            L_INC:   n_len = r_len + LW'(1);
            L_DEC:   n_len = r_len - LW'(1);
            default: n_len = r_len;
        endcase
        n_res = r_res;
        n_ok  = r_ok;
        case (i_cmd.res_op)
            R_FAIL: begin
                n_res = FAIL_WORD;
                n_ok  = 1'b0;
            end
            R_RDATA: n_res = r_rdata;
            R_INC:   n_res = r_res + 32'd1;
            R_IDX:   n_res = 32'(r_i);
            default: n_res = r_res;
        endcase
        if (i_cmd.load) begin
            n_res = '0;
            n_ok  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else begin
            r_len <= n_len;
        end
        r_i   <= n_i;
        r_j   <= n_j;
        r_res <= n_res;
        r_ok  <= n_ok;
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_res <= r_res;
            r_out_ok  <= r_ok;
            r_out_len <= 8'(r_len);
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out_res;
    assign o_ok     = r_out_ok;
    assign o_length = r_out_len;

    // status to controller
    always_comb begin
        o_sts.func       = r_func;
        o_sts.full       = (32'(r_len) >= 32'(CAPACITY));
        o_sts.empty      = (r_len == '0);
        o_sts.pos_bad    = (32'(r_pos) > 32'(r_len));
        o_sts.i_gt_pos   = (32'(r_i) > 32'(r_pos));
        o_sts.i_lt_len   = (r_i < r_len);
        o_sts.ip1_lt_len = ((33'(r_i) + 33'd1) < 33'(r_len));
        o_sts.ip1_lt_j   = ((33'(r_i) + 33'd1) < 33'(r_j));
        o_sts.inner_more = ((34'(r_j) + 34'(r_i) + 34'd1) < 34'(r_len));
        o_sts.eq         = (r_rdata == r_val);
        o_sts.gt         = ($signed(r_a) > $signed(r_rdata));
        o_sts.out_busy   = r_out_valid && i_stall;
    end

`ifndef SYNTHESIS
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_len) <= 32'(CAPACITY))
        else $error("list length above capacity");
    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> 32'(w_waddr) < 32'(CAPACITY))
        else $error("write beyond capacity");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_out_res)))
        else $error("stalled output word lost");
    a_load_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_out_valid && i_stall))
        else $error("output word overwritten");
`endif

endmodule

// ===== hw/rtl/ble_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_ctrl
// Sequencer that walks each list operation through the datapath.
// ----------------------------------------------------------------------------
module ble_ctrl import ble_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [17:0] {
        S_IDLE  = 18'h00001,
        S_EXEC  = 18'h00002,
        S_POPW  = 18'h00004,
        S_INS   = 18'h00008,
        S_INSW  = 18'h00010,
        S_SCAN  = 18'h00020,
        S_CHK   = 18'h00040,
        S_RM    = 18'h00080,
        S_RMW   = 18'h00100,
        S_RV    = 18'h00200,
        S_RVB   = 18'h00400,
        S_RVW   = 18'h00800,
        S_RVW2  = 18'h01000,
        S_SOP   = 18'h02000,
        S_SO    = 18'h04000,
        S_SOB   = 18'h08000,
        S_SOC   = 18'h10000,
        S_SOW   = 18'h20000
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;

    assign o_stall = (r_state != S_IDLE) || r_done;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_done  = r_done;
        o_cmd   = '{load: 1'b0, rd_en: 1'b0, rd_sel: A_I, wr_en: 1'b0, wr_sel: A_I,
                    wd_sel: D_VAL, ld_a: 1'b0, i_op: X_HOLD, j_op: X_HOLD,
                    len_op: L_HOLD, res_op: R_HOLD, out_load: 1'b0};
        case (r_state)
            S_IDLE: begin
                // hand the finished word to the output register
                if (r_done) begin
                    if (!i_sts.out_busy) begin
                        o_cmd.out_load = 1'b1;
                        n_done         = 1'b0;
                    end
                end else if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                case (i_sts.func)
                    F_APPEND: begin
                        if (i_sts.full) begin
                            o_cmd.res_op = R_FAIL;
                        end else begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wr_sel = A_LEN;
                            o_cmd.len_op = L_INC;
                        end
                    end
                    F_POP: begin
                        if (i_sts.empty) begin
                            o_cmd.res_op = R_FAIL;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = A_LENM1;
                            o_cmd.len_op = L_DEC;
                            n_state      = S_POPW;
                            n_done       = 1'b0;
                        end
                    end
                    F_INSERT: begin
                        if (i_sts.full || i_sts.pos_bad) begin
                            o_cmd.res_op = R_FAIL;
                        end else begin
                            o_cmd.i_op = X_LEN;
                            n_state    = S_INS;
                            n_done     = 1'b0;
                        end
                    end
                    F_REVERSE: begin
                        o_cmd.i_op = X_ZERO;
                        o_cmd.j_op = X_LEN;
                        n_state    = S_RV;
                        n_done     = 1'b0;
                    end
                    F_SORT: begin
                        o_cmd.i_op = X_ZERO;
                        n_state    = S_SOP;
                        n_done     = 1'b0;
                    end
                    default: begin
                        o_cmd.i_op = X_ZERO;
                        n_state    = S_SCAN;
                        n_done     = 1'b0;
                    end
                endcase
            end
            S_POPW: begin
                o_cmd.res_op = R_RDATA;
                n_state      = S_IDLE;
                n_done       = 1'b1;
            end
            // insert: shift tail up from the end, then place the value
            S_INS: begin
                if (i_sts.i_gt_pos) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = A_IM1;
                    n_state      = S_INSW;
                end else begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = A_POS;
                    o_cmd.len_op = L_INC;
                    n_state      = S_IDLE;
                    n_done       = 1'b1;
                end
            end
            S_INSW: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = A_I;
                o_cmd.wd_sel = D_RDATA;
                o_cmd.i_op   = X_DEC;
                n_state      = S_INS;
            end
            // linear scan for remove, count and find
            S_SCAN: begin
                if (i_sts.i_lt_len) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = A_I;
                    n_state      = S_CHK;
                end else begin
                    if (i_sts.func != F_COUNT) begin
                        o_cmd.res_op = R_FAIL;
                    end
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            S_CHK: begin
                n_state    = S_SCAN;
                o_cmd.i_op = X_INC;
                if (i_sts.eq) begin
                    case (i_sts.func)
                        F_COUNT: o_cmd.res_op = R_INC;
                        F_FIND: begin
                            o_cmd.res_op = R_IDX;
                            o_cmd.i_op   = X_HOLD;
                            n_state      = S_IDLE;
                            n_done       = 1'b1;
                        end
                        default: begin
                            o_cmd.i_op = X_HOLD;
                            n_state    = S_RM;
                        end
                    endcase
                end
            end
            // remove: shift later entries down
            S_RM: begin
                if (i_sts.ip1_lt_len) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = A_IP1;
                    n_state      = S_RMW;
                end else begin
                    o_cmd.len_op = L_DEC;
                    n_state      = S_IDLE;
                    n_done       = 1'b1;
                end
            end
            S_RMW: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = A_I;
                o_cmd.wd_sel = D_RDATA;
                o_cmd.i_op   = X_INC;
                n_state      = S_RM;
            end
            // reverse: swap entry i with entry j-1, walking inward
            S_RV: begin
                if (i_sts.ip1_lt_j) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = A_I;
                    n_state      = S_RVB;
                end else begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            S_RVB: begin
                o_cmd.ld_a   = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = A_JM1;
                n_state      = S_RVW;
            end
            S_RVW: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = A_I;
                o_cmd.wd_sel = D_RDATA;
                n_state      = S_RVW2;
            end
            S_RVW2: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = A_JM1;
                o_cmd.wd_sel = D_A;
                o_cmd.i_op   = X_INC;
                o_cmd.j_op   = X_DEC;
                n_state      = S_RV;
            end
            // bubble sort: i counts passes, j walks the unsorted part
            S_SOP: begin
                if (i_sts.ip1_lt_len) begin
                    o_cmd.j_op = X_ZERO;
                    n_state    = S_SO;
                end else begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            S_SO: begin
                if (i_sts.inner_more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = A_J;
                    n_state      = S_SOB;
                end else begin
                    o_cmd.i_op = X_INC;
                    n_state    = S_SOP;
                end
            end
            S_SOB: begin
                o_cmd.ld_a   = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = A_JP1;
                n_state      = S_SOC;
            end
            // out of order pair: lower slot takes entry j+1 first
            S_SOC: begin
                if (i_sts.gt) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = A_J;
                    o_cmd.wd_sel = D_RDATA;
                    n_state      = S_SOW;
                end else begin
                    o_cmd.j_op = X_INC;
                    n_state    = S_SO;
                end
            end
            // upper slot takes the saved entry j
            S_SOW: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = A_JP1;
                o_cmd.wd_sel = D_A;
                o_cmd.j_op   = X_INC;
                n_state      = S_SO;
            end
            default: begin
                n_state = S_IDLE;
                n_done  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

`ifndef SYNTHESIS
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_EXEC))
        else $error("accepted word not dispatched");
    a_idle_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_cmd.wr_en)
        else $error("memory write while idle");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("finished word outside idle");
`endif

endmodule

// ===== hw/rtl/bounded_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_list_engine
// Bounded list of signed words with append, pop, insert, remove, reverse,
// sort, count and find, run by a sequencer over a one-read, one-write list memory.
// ----------------------------------------------------------------------------
// each operation runs as a walk through sequencer states: insert and remove
// move one entry at a time, count and find scan one entry at a time, reverse
// swaps one pair at a time and sort makes n*(n-1)/2 compares, all bound by
// the one read and one write per cycle of the list memory; one word at a time.
// reset clears length, sequencer and output valid; memory is not cleared.
module bounded_list_engine import ble_pkg::*; #(
    parameter int CAPACITY = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_func,
    input  logic signed [31:0] i_value,
    input  logic [7:0]         i_position,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_result,
    output logic               o_ok,
    output logic [7:0]         o_length
);

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer
    ble_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // list memory and datapath
    ble_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_func     (i_func),
        .i_value    (i_value),
        .i_position (i_position),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (o_result),
        .o_ok       (o_ok),
        .o_length   (o_length)
    );

endmodule

// ===== tb/bounded_list_engine_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_list_engine_test
// Drives list commands through the word handshake, including full and empty
// lists, edge positions and sorts of short and full lists, while a scoreboard
// keeps its own copy of the list and checks every result word in order.
// ----------------------------------------------------------------------------
module bounded_list_engine_test;
    import ble_pkg::*;

    localparam int CAP = 128;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic signed [31:0] result;
        logic               ok;
        logic [7:0]         length;
    } t_list_reply;

    // list scoreboard with its own copy of the list
    class list_scoreboard;
        logic signed [31:0] entries[CAP];
        int                 count_now;
        t_list_reply        pending[$];
        int                 errors;
        int                 checked;

        function void note_command(t_func f, logic signed [31:0] v, logic [7:0] p);
            t_list_reply r;
            logic signed [31:0] t;
            int k;
            int m;
            int hit;
            r.result = 0;
            r.ok = 1'b1;
            hit = -1;
            for (k = 0; k < count_now; k++)
                if (hit < 0 && entries[k] == v) hit = k;
            case (f)
                F_APPEND: begin
                    if (count_now < CAP) begin
                        entries[count_now] = v;
                        count_now++;
                    end else begin
                        r.result = FAIL_WORD; r.ok = 1'b0;
                    end
                end
                F_POP: begin
                    if (count_now > 0) begin
                        count_now--;
                        r.result = entries[count_now];
                    end else begin
                        r.result = FAIL_WORD; r.ok = 1'b0;
                    end
                end
                F_INSERT: begin
                    if (count_now >= CAP || int'(p) > count_now) begin
                        r.result = FAIL_WORD; r.ok = 1'b0;
                    end else begin
                        for (k = count_now; k > int'(p); k--) entries[k] = entries[k-1];
                        entries[p] = v;
                        count_now++;
                    end
                end
                F_REMOVE: begin
                    if (hit >= 0) begin
                        for (k = hit; k + 1 < count_now; k++) entries[k] = entries[k+1];
                        count_now--;
                    end else begin
                        r.result = FAIL_WORD; r.ok = 1'b0;
                    end
                end
                F_REVERSE: begin
                    for (k = 0; k < count_now / 2; k++) begin
                        t = entries[k];
                        entries[k] = entries[count_now-1-k];
                        entries[count_now-1-k] = t;
                    end
                end
                F_SORT: begin
                    for (k = 0; k + 1 < count_now; k++)
                        for (m = 0; m + 1 < count_now - k; m++)
                            if (entries[m] > entries[m+1]) begin
                                t = entries[m];
                                entries[m] = entries[m+1];
                                entries[m+1] = t;
                            end
                end
                F_COUNT: begin
                    for (k = 0; k < count_now; k++)
                        if (entries[k] == v) r.result++;
                end
                default: begin
                    if (hit >= 0) r.result = hit;
                    else begin
                        r.result = FAIL_WORD; r.ok = 1'b0;
                    end
                end
            endcase
            r.length = count_now[7:0];
            pending.push_back(r);
        endfunction

        function string check_reply(t_list_reply got);
            t_list_reply want;
            checked++;
            if (pending.size() == 0) return "result word with nothing expected";
            want = pending.pop_front();
            if (got.result !== want.result)
                return $sformatf("result %0d, expected %0d", got.result, want.result);
            if (got.ok !== want.ok)
                return $sformatf("ok %0b, expected %0b", got.ok, want.ok);
            if (got.length !== want.length)
                return $sformatf("length %0d, expected %0d", got.length, want.length);
            return "";
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [2:0]         i_func;
    logic signed [31:0] i_value;
    logic [7:0]         i_position;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_result;
    logic               o_ok;
    logic [7:0]         o_length;

    list_scoreboard board;
    int send_idle_pct;
    int stall_pct;
    int hold_cycles;
    int quiet_cycles;
    int fail_count;
    int sent_words;
    logic [31:0] recent_vals[8];

    bounded_list_engine #(.CAPACITY(CAP)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_func(i_func), .i_value(i_value), .i_position(i_position),
        .o_valid(o_valid), .i_stall(i_stall), .o_result(o_result),
        .o_ok(o_ok), .o_length(o_length)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string msg);
        fail_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // send one command word, with random idle cycles ahead of it;
    // valid stays high on return so words can follow back to back
    task automatic send_word(t_func f, logic signed [31:0] v, logic [7:0] p);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= f;
        i_value <= v;
        i_position <= p;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_command(f, v, p);
        sent_words++;
        recent_vals[$urandom_range(7)] = v;
        @(negedge i_clk);
    endtask

    // stop sending and wait for every expected result
    task automatic drain_results;
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
    endtask

    // operands that often match list contents
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return recent_vals[$urandom_range(7)];
            default: return $signed(32'($urandom_range(15))) - 8;
        endcase
    endfunction

    task automatic send_random(int fill_bias);
        t_func f;
        int r;
        r = $urandom_range(99);
        if (r < fill_bias) f = ($urandom_range(1)) ? F_APPEND : F_INSERT;
        else f = t_func'($urandom_range(7));
        send_word(f, pick_value(), 8'($urandom_range(board.count_now + 2)));
    endtask

    // receiver stall and result checking
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && o_valid && !i_stall) begin
            msg = board.check_reply('{o_result, o_ok, o_length});
            if (msg != "") report_mismatch(msg);
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int k;
        int phase;
        board = new();
        board.count_now = 0;
        board.errors = 0;
        board.checked = 0;
        for (k = 0; k < 8; k++) recent_vals[k] = 0;
        fail_count = 0;
        sent_words = 0;
        quiet_cycles = 0;
        hold_cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_func = F_APPEND;
        i_value = 0;
        i_position = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty list cases, extremes, edge positions
        send_word(F_POP, 0, 0);
        send_word(F_REMOVE, 5, 0);
        send_word(F_FIND, 5, 0);
        send_word(F_COUNT, 5, 0);
        send_word(F_REVERSE, 0, 0);
        send_word(F_SORT, 0, 0);
        send_word(F_INSERT, 7, 8'd1);
        send_word(F_INSERT, 32'sh7FFF_FFFF, 8'd0);
        send_word(F_REVERSE, 0, 0);
        send_word(F_SORT, 0, 0);
        send_word(F_APPEND, 32'sh8000_0000, 8'hFF);
        send_word(F_INSERT, -1, 8'd1);
        send_word(F_INSERT, 0, 8'd3);
        send_word(F_APPEND, -1, 0);
        send_word(F_COUNT, -1, 0);
        send_word(F_FIND, -1, 0);
        send_word(F_SORT, 0, 0);
        send_word(F_REVERSE, 0, 0);
        send_word(F_REMOVE, -1, 0);
        send_word(F_FIND, 32'sh8000_0000, 0);
        send_word(F_INSERT, 1, 8'd200);
        send_word(F_POP, 0, 0);

        // fill to capacity, refusals when full, sort and reverse a full list
        while (board.count_now < CAP) send_word(F_APPEND, $urandom, 8'($urandom));
        send_word(F_APPEND, 1, 0);
        send_word(F_INSERT, 1, 8'd0);
        send_word(F_SORT, 0, 0);
        send_word(F_REVERSE, 0, 0);
        send_word(F_INSERT, 1, 8'd128);
        send_word(F_REMOVE, board.entries[CAP-1], 0);
        send_word(F_INSERT, 2, 8'd127);
        while (board.count_now > 0) send_word(F_POP, 0, 0);
        drain_results();

        // long receiver hold while commands keep coming
        hold_cycles = 3000;
        for (k = 0; k < 40; k++) send_word(F_APPEND, pick_value(), 0);
        drain_results();

        // random phases with different idle patterns
        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 64; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 64; end
                default: begin send_idle_pct = 13; stall_pct = 13; end
            endcase
            for (k = 0; k < 170; k++) begin
                if (board.count_now < 10) send_random(60);
                else if (board.count_now > 100) send_random(0);
                else send_random(30);
            end
            // shrink the list now and then so sorts stay short
            if (phase % 2 == 1) while (board.count_now > 4) send_word(F_POP, 0, 0);
            drain_results();
        end

        stall_pct = 0;
        drain_results();
        repeat (2000) @(negedge i_clk);
        if (board.pending.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", board.pending.size()));
        $display("ran %0d command words, %0d result words checked, all eight commands",
                 sent_words, board.checked);
        $display("covered empty and full lists, edge positions and long output stalls");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
